FILE: hdl/phta_pkg.sv
// Shared types, constants and codes for the per-host traffic accounting block.
package phta_pkg;

  localparam int TABLE_SLOTS = 4096;
  localparam int PROBE_LIMIT = 4;
  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int ADDR_W = SLOT_W + 1;
  localparam int ALL_SLOTS = 2 * TABLE_SLOTS;
  localparam int PRB_W = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;

  localparam int BYTE_W = 48;
  localparam int CNT_W = 32;
  localparam int LEN_W = 17;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [LEN_W-1:0] FRAME_OVERHEAD = 17'd18;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [31:0] BCAST_ADDR = 32'hFFFF_FFFF;
  localparam logic [31:0] LOCAL_NET_B_RESET = 32'd8011306;

  // Operation codes.
  localparam logic [1:0] OP_COUNT = 2'd0;
  localparam logic [1:0] OP_READ_ENTRY = 2'd1;
  localparam logic [1:0] OP_READ_TOTALS = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_COUNTED = 3'd0;
  localparam logic [2:0] ST_NOT_IP = 3'd1;
  localparam logic [2:0] ST_TOTALS_ONLY = 3'd2;
  localparam logic [2:0] ST_TABLE_FULL = 3'd3;
  localparam logic [2:0] ST_READ_DONE = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LOCAL_NET_A = 2'd0;
  localparam logic [1:0] CFG_LOCAL_NET_B = 2'd1;
  localparam logic [1:0] CFG_NET_MASK = 2'd2;

  // One host slot as stored in the table memory.
  typedef struct packed {
    logic              used;
    logic [31:0]       host;
    logic [BYTE_W-1:0] bytes;
    logic [CNT_W-1:0]  packets;
    logic [BYTE_W-1:0] rx_bytes;
    logic [CNT_W-1:0]  rx_packets;
    logic [CNT_W-1:0]  tcp;
    logic [CNT_W-1:0]  udp;
    logic [CNT_W-1:0]  icmp;
    logic [CNT_W-1:0]  other;
  } entry_t;

  localparam int ENT_W = $bits(entry_t);

  // Request to the shared saturating adder.
  typedef struct packed {
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic              narrow;
  } alu_req_t;

endpackage

FILE: hdl/phta_ram.sv
// Generic single-port RAM with registered read data.
module phta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and read the addressed word into the output register.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: hdl/phta_sat_alu.sv
// Shared saturating adder used for every counter update.
module phta_sat_alu import phta_pkg::*; (
  input  alu_req_t          req,
  output logic [BYTE_W-1:0] y
);

  logic [BYTE_W:0]   sum;
  logic [BYTE_W:0]   limit;

  // Add, then clamp at the 32-bit or 48-bit ceiling.
  always_comb begin
    sum = {1'b0, req.a} + {1'b0, req.b};
    limit = req.narrow ? {{(BYTE_W - CNT_W + 1){1'b0}}, {CNT_W{1'b1}}}
                       : {1'b0, {BYTE_W{1'b1}}};
    if (sum > limit) begin
      y = limit[BYTE_W-1:0];
    end else begin
      y = sum[BYTE_W-1:0];
    end
  end

endmodule

FILE: hdl/per_host_traffic_accounting.sv
// Top level: sequencer, host table memory and totals of the traffic accounting block.
// Steps: accept, classify, then per host up to PROBE_LIMIT probes and, if a slot is found,
// an update and write-back of the entry; then the totals and the result. Local frames skip
// the host table, in-range entry reads read one slot, other items go straight to the result.
// One item at a time until its result is taken: the table port and the adder are single.
// After reset a clearing pass writes all 8192 slots, one a cycle, before items are taken.
module per_host_traffic_accounting import phta_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_operation,
  input  logic [15:0]       in_ether_type,
  input  logic [15:0]       in_ip_length,
  input  logic [7:0]        in_protocol,
  input  logic [31:0]       in_src_addr,
  input  logic [31:0]       in_dst_addr,
  input  logic              in_table_select,
  input  logic [11:0]       in_slot,
  input  logic              in_clear_after,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_status,
  output logic [31:0]       out_host_key,
  output logic              out_entry_valid,
  output logic [BYTE_W-1:0] out_byte_count,
  output logic [CNT_W-1:0]  out_packet_count,
  output logic [BYTE_W-1:0] out_inbound_bytes,
  output logic [CNT_W-1:0]  out_inbound_packets,
  output logic [CNT_W-1:0]  out_tcp_count,
  output logic [CNT_W-1:0]  out_udp_count,
  output logic [CNT_W-1:0]  out_icmp_count,
  output logic [CNT_W-1:0]  out_other_count,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CLS    = 4'd2;
  localparam logic [3:0] S_PRB_RD = 4'd3;
  localparam logic [3:0] S_PRB_EV = 4'd4;
  localparam logic [3:0] S_UPD    = 4'd5;
  localparam logic [3:0] S_WR     = 4'd6;
  localparam logic [3:0] S_TOT    = 4'd7;
  localparam logic [3:0] S_RD_A   = 4'd8;
  localparam logic [3:0] S_RD_EV  = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0]        state_r;
  logic [ADDR_W-1:0] clr_cnt_r;

  logic [31:0] net_a_r, net_b_r, mask_r;

  // Latched item fields.
  logic [LEN_W-1:0] len_r;
  logic [7:0]  proto_r;
  logic [31:0] src_r, dst_r;
  logic        clr_r;
  logic [ADDR_W-1:0] rd_addr_r;

  // Count plan and probe state.
  logic [31:0]       key0_r, key1_r;
  logic              two_hosts_r, inb_r, sum_in_r, loc_r, full_r;
  logic              hidx_r;
  logic [PRB_W-1:0]  prb_r;
  logic              free_found_r;
  logic [ADDR_W-1:0] free_idx_r, probe_addr_r, idx_r;
  logic [2:0]        step_r;
  entry_t            ent_r;

  logic [BYTE_W-1:0] sum_rx_bytes_r, sum_out_bytes_r;
  logic [CNT_W-1:0]  sum_in_pkts_r, sum_out_pkts_r;

  // Output register.
  logic [2:0]        o_status_r;
  logic [31:0]       o_host_r;
  logic              o_valid_ent_r;
  logic [BYTE_W-1:0] o_bytes_r, o_rx_bytes_r;
  logic [CNT_W-1:0]  o_pkts_r, o_in_pkts_r, o_tcp_r, o_udp_r, o_icmp_r, o_other_r;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [ENT_W-1:0]  ram_wdata, ram_rdata;
  entry_t            rd_ent;
  entry_t            cleared_ent;
  entry_t            new_ent;

  alu_req_t          alu_req;
  logic [BYTE_W-1:0] alu_y;

  logic [31:0]       key_cur;
  logic [SLOT_W-1:0] probe_slot;
  logic [31:0]       slot_wide;
  logic              slot_oor;
  logic [31:0]       ms, md;
  logic              is_out, is_in, is_loc;
  logic              hit, last_probe;
  logic [BYTE_W-1:0] len_ext;

  phta_ram #(.WIDTH(ENT_W), .DEPTH(ALL_SLOTS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  phta_sat_alu u_alu (
    .req (alu_req),
    .y   (alu_y)
  );

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign cfg_ready = 1'b1;

  assign out_status = o_status_r;
  assign out_host_key = o_host_r;
  assign out_entry_valid = o_valid_ent_r;
  assign out_byte_count = o_bytes_r;
  assign out_packet_count = o_pkts_r;
  assign out_inbound_bytes = o_rx_bytes_r;
  assign out_inbound_packets = o_in_pkts_r;
  assign out_tcp_count = o_tcp_r;
  assign out_udp_count = o_udp_r;
  assign out_icmp_count = o_icmp_r;
  assign out_other_count = o_other_r;

  // Classification and probe addressing.
  always_comb begin
    rd_ent = entry_t'(ram_rdata);
    cleared_ent = rd_ent;
    cleared_ent.used = 1'b0;
    key_cur = hidx_r ? key1_r : key0_r;
    new_ent = '0;
    new_ent.used = 1'b1;
    new_ent.host = key_cur;
    probe_slot = key_cur[SLOT_W-1:0] + SLOT_W'(prb_r);
    slot_wide = 32'(in_slot);
    slot_oor = (slot_wide >= 32'(TABLE_SLOTS));
    ms = src_r & mask_r;
    md = dst_r & mask_r;
    is_out = (ms == net_a_r && md != net_a_r) || (ms == net_b_r && md != net_b_r);
    is_in = (md == net_a_r && ms != net_a_r) || (md == net_b_r && ms != net_b_r);
    is_loc = (md == net_a_r && ms == net_a_r) || (md == net_b_r && ms == net_b_r) ||
             (src_r == 32'd0) || (dst_r == BCAST_ADDR);
    hit = rd_ent.used && (rd_ent.host == key_cur);
    last_probe = (prb_r == PRB_W'(PROBE_LIMIT - 1));
    len_ext = BYTE_W'(len_r);
  end

  // Table port selection.
  always_comb begin
    ram_we = 1'b0;
    ram_addr = idx_r;
    ram_wdata = ent_r;
    case (state_r)
      S_CLR: begin
        ram_we = 1'b1;
        ram_addr = clr_cnt_r;
        ram_wdata = '0;
      end
      S_PRB_RD: begin
        ram_addr = {hidx_r, probe_slot};
      end
      S_WR: begin
        ram_we = 1'b1;
      end
      S_RD_A: begin
        ram_addr = rd_addr_r;
      end
      S_RD_EV: begin
        ram_addr = rd_addr_r;
        ram_we = rd_ent.used && clr_r;
        ram_wdata = cleared_ent;
      end
      default: begin
        ram_addr = idx_r;
      end
    endcase
  end

  // Operand selection for the shared adder.
  always_comb begin
    alu_req = '{a: '0, b: '0, narrow: 1'b1};
    if (state_r == S_TOT) begin
      if (step_r == 3'd0) begin
        alu_req.a = sum_in_r ? sum_rx_bytes_r : sum_out_bytes_r;
        alu_req.b = len_ext;
        alu_req.narrow = 1'b0;
      end else begin
        alu_req.a = BYTE_W'(sum_in_r ? sum_in_pkts_r : sum_out_pkts_r);
        alu_req.b = BYTE_W'(1);
      end
    end else begin
      case (step_r)
        3'd0: begin
          alu_req.a = ent_r.bytes;
          alu_req.b = len_ext;
          alu_req.narrow = 1'b0;
        end
        3'd1: begin
          alu_req.a = BYTE_W'(ent_r.packets);
          alu_req.b = BYTE_W'(1);
        end
        3'd2: begin
          alu_req.a = ent_r.rx_bytes;
          alu_req.b = inb_r ? len_ext : '0;
          alu_req.narrow = 1'b0;
        end
        3'd3: begin
          alu_req.a = BYTE_W'(ent_r.rx_packets);
          alu_req.b = BYTE_W'(inb_r);
        end
        default: begin
          alu_req.b = BYTE_W'(1);
          if (proto_r == PROTO_TCP) begin
            alu_req.a = BYTE_W'(ent_r.tcp);
          end else if (proto_r == PROTO_UDP) begin
            alu_req.a = BYTE_W'(ent_r.udp);
          end else if (proto_r == PROTO_ICMP) begin
            alu_req.a = BYTE_W'(ent_r.icmp);
          end else begin
            alu_req.a = BYTE_W'(ent_r.other);
          end
        end
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_cnt_r <= '0;
      net_a_r <= '0;
      net_b_r <= LOCAL_NET_B_RESET;
      mask_r <= '0;
      sum_rx_bytes_r <= '0;
      sum_out_bytes_r <= '0;
      sum_in_pkts_r <= '0;
      sum_out_pkts_r <= '0;
      full_r <= 1'b0;
      free_found_r <= 1'b0;
      hidx_r <= 1'b0;
      prb_r <= '0;
      step_r <= '0;
    end else begin
      // Configuration writes.
      if (cfg_valid) begin
        case (cfg_index)
          CFG_LOCAL_NET_A: net_a_r <= cfg_data;
          CFG_LOCAL_NET_B: net_b_r <= cfg_data;
          CFG_NET_MASK: mask_r <= cfg_data;
          default: ;
        endcase
      end

      case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
          if (clr_cnt_r == ADDR_W'(ALL_SLOTS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            len_r <= LEN_W'(in_ip_length) + FRAME_OVERHEAD;
            proto_r <= in_protocol;
            src_r <= in_src_addr;
            dst_r <= in_dst_addr;
            clr_r <= in_clear_after;
            rd_addr_r <= {in_table_select, slot_wide[SLOT_W-1:0]};
            o_host_r <= '0;
            o_valid_ent_r <= 1'b0;
            o_tcp_r <= '0;
            o_udp_r <= '0;
            o_icmp_r <= '0;
            o_other_r <= '0;
            full_r <= 1'b0;
            // Totals reads return the sums; every other item starts from zero.
            if (in_operation == OP_READ_TOTALS) begin
              o_bytes_r <= sum_out_bytes_r;
              o_pkts_r <= sum_out_pkts_r;
              o_rx_bytes_r <= sum_rx_bytes_r;
              o_in_pkts_r <= sum_in_pkts_r;
            end else begin
              o_bytes_r <= '0;
              o_pkts_r <= '0;
              o_rx_bytes_r <= '0;
              o_in_pkts_r <= '0;
            end
            case (in_operation)
              OP_COUNT: begin
                if (in_ether_type != ETYPE_IPV4) begin
                  o_status_r <= ST_NOT_IP;
                  state_r <= S_DONE;
                end else begin
                  o_status_r <= ST_COUNTED;
                  state_r <= S_CLS;
                end
              end
              OP_READ_ENTRY: begin
                o_status_r <= ST_READ_DONE;
                state_r <= slot_oor ? S_DONE : S_RD_A;
              end
              OP_READ_TOTALS: begin
                o_status_r <= ST_READ_DONE;
                if (in_clear_after) begin
                  sum_rx_bytes_r <= '0;
                  sum_out_bytes_r <= '0;
                  sum_in_pkts_r <= '0;
                  sum_out_pkts_r <= '0;
                end
                state_r <= S_DONE;
              end
              default: begin
                o_status_r <= ST_READ_DONE;
                state_r <= S_DONE;
              end
            endcase
          end
        end
        S_CLS: begin
          hidx_r <= 1'b0;
          prb_r <= '0;
          free_found_r <= 1'b0;
          step_r <= '0;
          if (is_out) begin
            key0_r <= src_r;
            key1_r <= dst_r;
            two_hosts_r <= 1'b1;
            inb_r <= 1'b0;
            sum_in_r <= 1'b0;
            loc_r <= 1'b0;
            state_r <= S_PRB_RD;
          end else if (is_in) begin
            key0_r <= dst_r;
            key1_r <= src_r;
            two_hosts_r <= 1'b1;
            inb_r <= 1'b1;
            sum_in_r <= 1'b1;
            loc_r <= 1'b0;
            state_r <= S_PRB_RD;
          end else if (is_loc) begin
            loc_r <= 1'b1;
            sum_in_r <= 1'b1;
            state_r <= S_TOT;
          end else begin
            key0_r <= src_r;
            two_hosts_r <= 1'b0;
            inb_r <= 1'b0;
            sum_in_r <= 1'b0;
            loc_r <= 1'b0;
            state_r <= S_PRB_RD;
          end
        end
        S_PRB_RD: begin
          probe_addr_r <= {hidx_r, probe_slot};
          state_r <= S_PRB_EV;
        end
        S_PRB_EV: begin
          if (hit) begin
            ent_r <= rd_ent;
            idx_r <= probe_addr_r;
            step_r <= '0;
            state_r <= S_UPD;
          end else begin
            if (!rd_ent.used && !free_found_r) begin
              free_found_r <= 1'b1;
              free_idx_r <= probe_addr_r;
            end
            if (last_probe) begin
              if (free_found_r || !rd_ent.used) begin
                ent_r <= new_ent;
                idx_r <= free_found_r ? free_idx_r : probe_addr_r;
                step_r <= '0;
                state_r <= S_UPD;
              end else begin
                // Probe window full: this table is left alone.
                full_r <= 1'b1;
                step_r <= '0;
                if (!hidx_r && two_hosts_r) begin
                  hidx_r <= 1'b1;
                  prb_r <= '0;
                  free_found_r <= 1'b0;
                  state_r <= S_PRB_RD;
                end else begin
                  state_r <= S_TOT;
                end
              end
            end else begin
              prb_r <= prb_r + PRB_W'(1);
              state_r <= S_PRB_RD;
            end
          end
        end
        S_UPD: begin
          step_r <= step_r + 3'd1;
          case (step_r)
            3'd0: ent_r.bytes <= alu_y;
            3'd1: ent_r.packets <= alu_y[CNT_W-1:0];
            3'd2: ent_r.rx_bytes <= alu_y;
            3'd3: ent_r.rx_packets <= alu_y[CNT_W-1:0];
            default: begin
              if (proto_r == PROTO_TCP) begin
                ent_r.tcp <= alu_y[CNT_W-1:0];
              end else if (proto_r == PROTO_UDP) begin
                ent_r.udp <= alu_y[CNT_W-1:0];
              end else if (proto_r == PROTO_ICMP) begin
                ent_r.icmp <= alu_y[CNT_W-1:0];
              end else begin
                ent_r.other <= alu_y[CNT_W-1:0];
              end
              state_r <= S_WR;
            end
          endcase
        end
        S_WR: begin
          step_r <= '0;
          if (!hidx_r && two_hosts_r) begin
            hidx_r <= 1'b1;
            prb_r <= '0;
            free_found_r <= 1'b0;
            state_r <= S_PRB_RD;
          end else begin
            state_r <= S_TOT;
          end
        end
        S_TOT: begin
          step_r <= step_r + 3'd1;
          if (step_r == 3'd0) begin
            if (sum_in_r) begin
              sum_rx_bytes_r <= alu_y;
            end else begin
              sum_out_bytes_r <= alu_y;
            end
          end else begin
            if (sum_in_r) begin
              sum_in_pkts_r <= alu_y[CNT_W-1:0];
            end else begin
              sum_out_pkts_r <= alu_y[CNT_W-1:0];
            end
            if (loc_r) begin
              o_status_r <= ST_TOTALS_ONLY;
            end else begin
              o_status_r <= full_r ? ST_TABLE_FULL : ST_COUNTED;
            end
            state_r <= S_DONE;
          end
        end
        S_RD_A: begin
          state_r <= S_RD_EV;
        end
        S_RD_EV: begin
          if (rd_ent.used) begin
            o_host_r <= rd_ent.host;
            o_valid_ent_r <= 1'b1;
            o_bytes_r <= rd_ent.bytes;
            o_pkts_r <= rd_ent.packets;
            o_rx_bytes_r <= rd_ent.rx_bytes;
            o_in_pkts_r <= rd_ent.rx_packets;
            o_tcp_r <= rd_ent.tcp;
            o_udp_r <= rd_ent.udp;
            o_icmp_r <= rd_ent.icmp;
            o_other_r <= rd_ent.other;
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
